### rtl/ipv6p_pkg.sv
`default_nettype none

package ipv6p_pkg;

    localparam int unsigned NumGroups = 8;
    localparam int unsigned GroupW    = 16;

    typedef logic [0:NumGroups-1][GroupW-1:0] group_vec_t;

    typedef struct packed {
        logic [15:0] hex_word;
        logic [2:0]  nibble_count;
        logic [3:0]  groups_left;
        logic [3:0]  gap_index;
        logic        gap_seen;
        logic        after_colon;
        logic        at_start;
        logic        dotted_mode;
        logic [8:0]  decimal_octet;
        logic        decimal_only;
        logic [2:0]  dot_count;
        logic [23:0] dotted_value;
        logic        error_seen;
    } parse_ctl_t;

    localparam parse_ctl_t CtlReset = '{
        hex_word:      16'h0000,
        nibble_count:  3'd0,
        groups_left:   4'd8,
        gap_index:     4'd0,
        gap_seen:      1'b0,
        after_colon:   1'b0,
        at_start:      1'b1,
        dotted_mode:   1'b0,
        decimal_octet: 9'd0,
        decimal_only:  1'b1,
        dot_count:     3'd0,
        dotted_value:  24'h000000,
        error_seen:    1'b0
    };

    localparam logic [3:0] AllGroups = 4'd8;
    localparam logic [8:0] OctetMax  = 9'd255;
    localparam logic [2:0] DotsFull  = 3'd3;

endpackage

`default_nettype wire

### rtl/ipv6p_char.sv
`default_nettype none

module ipv6p_char (
    input  wire  ipv6p_pkg::parse_ctl_t ctl_i,
    input  wire  ipv6p_pkg::group_vec_t head_i,
    input  wire  ipv6p_pkg::group_vec_t tail_i,
    input  wire  logic [7:0]            char_i,
    output       ipv6p_pkg::parse_ctl_t ctl_o,
    output       ipv6p_pkg::group_vec_t head_o,
    output       ipv6p_pkg::group_vec_t tail_o
);
    import ipv6p_pkg::*;

    localparam logic [7:0] ChColon  = 8'h3a;
    localparam logic [7:0] ChDot    = 8'h2e;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowF   = 8'h66;
    localparam logic [7:0] CaseBit  = 8'h20;
    localparam logic [3:0] NibFull  = 4'd4;
    localparam logic [8:0] OctetSat = 9'd256;

    function automatic logic [8:0] dec_push(input logic [8:0] v, input logic [3:0] d);
        logic [12:0] r;
        r = {4'b0000, v} * 13'd10 + {9'b0, d};
        return (r > {4'b0000, OctetSat}) ? OctetSat : r[8:0];
    endfunction

    logic       is_colon;
    logic       is_dot;
    logic       is_dec;
    logic       is_af;
    logic [7:0] lower_c;
    logic [3:0] hex_val;
    logic [3:0] used_groups;
    logic [3:0] left_after;
    logic [8:0] octet_new;
    logic       skip;

    assign is_colon    = (char_i == ChColon);
    assign is_dot      = (char_i == ChDot);
    assign is_dec      = (char_i >= ChZero) && (char_i <= ChNine);
    assign lower_c     = char_i | CaseBit;
    assign is_af       = (lower_c >= ChLowA) && (lower_c <= ChLowF);
    assign hex_val     = is_dec ? char_i[3:0] : (lower_c[3:0] + 4'd9);
    assign used_groups = AllGroups - ctl_i.groups_left;
    assign left_after  = ctl_i.groups_left - 4'd1;

    always_comb begin
        ctl_o     = ctl_i;
        head_o    = head_i;
        tail_o    = tail_i;
        skip      = 1'b0;
        octet_new = 9'd0;
        if (!ctl_i.error_seen) begin
            if (ctl_i.at_start) begin
                ctl_o.at_start = 1'b0;
                skip           = is_colon;
            end
            if (!skip) begin
                if (ctl_i.dotted_mode) begin
                    priority if (is_dec) begin
                        octet_new           = dec_push(ctl_i.decimal_octet, char_i[3:0]);
                        ctl_o.decimal_octet = octet_new;
                        if (octet_new > OctetMax) begin
                            ctl_o.error_seen = 1'b1;
                        end
                    end else if (is_dot) begin
                        if (ctl_i.dot_count >= DotsFull) begin
                            ctl_o.error_seen = 1'b1;
                        end else begin
                            ctl_o.dotted_value  = {ctl_i.dotted_value[15:0],
                                                   ctl_i.decimal_octet[7:0]};
                            ctl_o.dot_count     = ctl_i.dot_count + 3'd1;
                            ctl_o.decimal_octet = 9'd0;
                        end
                    end else begin
                        ctl_o.error_seen = 1'b1;
                    end
                end else begin
                    priority if (is_colon) begin
                        if (ctl_i.nibble_count != 3'd0) begin
                            head_o[used_groups[2:0]] = ctl_i.hex_word;
                            tail_o = {tail_i[1:NumGroups-1], ctl_i.hex_word};
                            ctl_o.groups_left = left_after;
                            if (left_after == 4'd0) begin
                                ctl_o.error_seen = 1'b1;
                            end else begin
                                ctl_o.hex_word      = 16'h0000;
                                ctl_o.nibble_count  = 3'd0;
                                ctl_o.decimal_octet = 9'd0;
                                ctl_o.decimal_only  = 1'b1;
                                ctl_o.after_colon   = 1'b1;
                            end
                        end else if (!ctl_i.gap_seen) begin
                            ctl_o.gap_seen    = 1'b1;
                            ctl_o.gap_index   = used_groups;
                            ctl_o.after_colon = 1'b1;
                        end else begin
                            ctl_o.error_seen = 1'b1;
                        end
                    end else if (is_dot && (ctl_i.nibble_count != 3'd0)) begin
                        if ((ctl_i.groups_left < 4'd2) || !ctl_i.after_colon ||
                            !ctl_i.decimal_only || (ctl_i.decimal_octet > OctetMax)) begin
                            ctl_o.error_seen = 1'b1;
                        end else begin
                            ctl_o.dotted_mode   = 1'b1;
                            ctl_o.dotted_value  = {15'b0, ctl_i.decimal_octet};
                            ctl_o.dot_count     = 3'd1;
                            ctl_o.decimal_octet = 9'd0;
                        end
                    end else if ({1'b0, ctl_i.nibble_count} >= NibFull) begin
                        ctl_o.error_seen = 1'b1;
                    end else if (!(is_dec || is_af)) begin
                        ctl_o.error_seen = 1'b1;
                    end else begin
                        ctl_o.nibble_count = ctl_i.nibble_count + 3'd1;
                        ctl_o.hex_word     = {ctl_i.hex_word[11:0], hex_val};
                        if (is_dec) begin
                            ctl_o.decimal_octet = dec_push(ctl_i.decimal_octet, hex_val);
                        end else begin
                            ctl_o.decimal_only = 1'b0;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ipv6p_finish.sv
`default_nettype none

module ipv6p_finish (
    input  wire  ipv6p_pkg::parse_ctl_t ctl_i,
    input  wire  ipv6p_pkg::group_vec_t head_i,
    input  wire  ipv6p_pkg::group_vec_t tail_i,
    output       logic                  valid_o,
    output       ipv6p_pkg::group_vec_t addr_o
);
    import ipv6p_pkg::*;

    logic        shape_ok;
    logic        ok;
    logic [3:0]  left_final;
    logic [31:0] ip_word;
    logic [4:0]  zero_end;
    group_vec_t  tail_final;
    group_vec_t  merged;

    assign ip_word = {ctl_i.dotted_value, ctl_i.decimal_octet[7:0]};

    always_comb begin
        if (ctl_i.dotted_mode) begin
            shape_ok   = (ctl_i.dot_count == DotsFull) && (ctl_i.decimal_octet <= OctetMax);
            tail_final = {tail_i[2:NumGroups-1], ip_word[31:16], ip_word[15:0]};
            left_final = ctl_i.groups_left - 4'd2;
        end else begin
            shape_ok   = (ctl_i.nibble_count != 3'd0) || ctl_i.gap_seen;
            tail_final = {tail_i[1:NumGroups-1], ctl_i.hex_word};
            left_final = ctl_i.groups_left - 4'd1;
        end
        ok = !ctl_i.error_seen && shape_ok && ((left_final != 4'd0) == ctl_i.gap_seen);
    end

    assign zero_end = {1'b0, ctl_i.gap_index} + {1'b0, left_final};

    always_comb begin
        for (int i = 0; i < NumGroups; i++) begin
            priority if (!ctl_i.gap_seen) begin
                merged[i] = tail_final[i];
            end else if (5'(i) < {1'b0, ctl_i.gap_index}) begin
                merged[i] = head_i[i];
            end else if (5'(i) < zero_end) begin
                merged[i] = '0;
            end else begin
                merged[i] = tail_final[i];
            end
        end
    end

    assign valid_o = ok;
    assign addr_o  = ok ? merged : '0;

endmodule

`default_nettype wire

### rtl/ipv6_text_to_binary_parser.sv
// The word that ends the text is taken from the s_ side into the input stage; its result is
// then registered in the output stage that drives the m_ side.
// Throughput: one character word per cycle outside a stall, set by the parse state register loop.
// The s_ side stalls only while a finished result waits to be taken.
// Reset (aresetn low, synchronous) empties both stages and returns the parse state to idle.
`default_nettype none

module ipv6_text_to_binary_parser (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    input  wire  logic        s_valid,
    output       logic        s_ready,
    input  wire  logic [7:0]  s_char_code,
    input  wire  logic        s_end_only,
    input  wire  logic        s_last_char,
    output       logic        m_valid,
    input  wire  logic        m_ready,
    output       logic        m_is_valid,
    output       logic [63:0] m_addr_upper,
    output       logic [63:0] m_addr_lower
);
    import ipv6p_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic        last_reg;
    parse_ctl_t  ctl_reg;
    group_vec_t  head_reg;
    group_vec_t  tail_reg;
    logic        out_valid_reg;
    logic        is_valid_reg;
    group_vec_t  addr_reg;

    parse_ctl_t  char_ctl;
    group_vec_t  char_head;
    group_vec_t  char_tail;
    parse_ctl_t  mid_ctl;
    group_vec_t  mid_head;
    group_vec_t  mid_tail;
    logic        fin_valid;
    group_vec_t  fin_addr;
    logic        ends_text;
    logic        advance;

    ipv6p_char u_char (
        .ctl_i  (ctl_reg),
        .head_i (head_reg),
        .tail_i (tail_reg),
        .char_i (char_reg),
        .ctl_o  (char_ctl),
        .head_o (char_head),
        .tail_o (char_tail)
    );

    assign mid_ctl  = end_reg ? ctl_reg  : char_ctl;
    assign mid_head = end_reg ? head_reg : char_head;
    assign mid_tail = end_reg ? tail_reg : char_tail;

    ipv6p_finish u_finish (
        .ctl_i   (mid_ctl),
        .head_i  (mid_head),
        .tail_i  (mid_tail),
        .valid_o (fin_valid),
        .addr_o  (fin_addr)
    );

    assign ends_text = end_reg || last_reg;
    assign advance   = in_valid_reg && (!ends_text || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
            end_reg  <= s_end_only;
            last_reg <= s_last_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= CtlReset;
        end else if (advance) begin
            ctl_reg <= ends_text ? CtlReset : char_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            head_reg <= mid_head;
            tail_reg <= mid_tail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && ends_text) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ends_text) begin
            is_valid_reg <= fin_valid;
            addr_reg     <= fin_addr;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_is_valid   = is_valid_reg;
    assign m_addr_upper = addr_reg[0:3];
    assign m_addr_lower = addr_reg[4:7];

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !is_valid_reg |-> (addr_reg == '0))
        else $error("invalid result carries a nonzero address");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ends_text |=> (ctl_reg == CtlReset))
        else $error("parse state not cleared after end of text");

    a_groups_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.groups_left <= AllGroups)
        else $error("group count out of range");

    a_dots_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.dotted_mode |-> (ctl_reg.dot_count != 3'd0) && (ctl_reg.dot_count <= DotsFull))
        else $error("dot count out of range in dotted tail");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !(advance && ends_text))
        else $error("result overwritten while waiting");

endmodule

`default_nettype wire
